// File: design/dbm_pkg.sv
// ----------------------------------------------------------------------------
// dbm_pkg: shared types and constants for the baseband modulator
// word formats, mode and modulation codes, csr indexes and reset values
// ----------------------------------------------------------------------------
package dbm_pkg;

   // sample format is signed q1.15
   localparam int SAMPLE_WIDTH = 16;
   localparam int AMP_WIDTH    = 15;

   // request word field widths
   localparam int MODE_WIDTH = 2;
   localparam int ADDR_WIDTH = 8;

   // request modes
   localparam logic [MODE_WIDTH-1:0] MODE_TICK    = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_WRITE   = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_RESTART = 2'd2;

   // modulation types
   localparam logic [1:0] MOD_OOK  = 2'd0;
   localparam logic [1:0] MOD_ASK  = 2'd1;
   localparam logic [1:0] MOD_BPSK = 2'd2;
   localparam logic [1:0] MOD_QPSK = 2'd3;

   // csr port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MOD_TYPE     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AMPLITUDE    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SAMPLES_BIT  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BIT_COUNT    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_LENGTH = 3'd4;

   // csr reset values
   localparam logic [1:0]           RST_MOD_TYPE     = MOD_OOK;
   localparam logic [AMP_WIDTH-1:0] RST_AMPLITUDE    = 15'd16384;
   localparam logic [15:0]          RST_SAMPLES_BIT  = 16'd8;
   localparam logic [8:0]           RST_BIT_COUNT    = 9'd8;
   localparam logic [15:0]          RST_FRAME_LENGTH = 16'd64;

   typedef struct packed {
      logic [MODE_WIDTH-1:0] mode;
      logic [ADDR_WIDTH-1:0] bit_address;
      logic                  bit_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] in_phase;
      logic signed [SAMPLE_WIDTH-1:0] quadrature;
   } rsp_type;

endpackage

// File: design/dbm_ram.sv
// ----------------------------------------------------------------------------
// dbm_ram: generic single-write, single-read memory
// one write port, one read port with registered read data and read enable
// ----------------------------------------------------------------------------
module dbm_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 128,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/digital_baseband_modulator.sv
// ----------------------------------------------------------------------------
// digital_baseband_modulator: ook / ask / bpsk / qpsk i/q sample source
// frame bit store plus sample, bit and position counters; one sample per tick
// ----------------------------------------------------------------------------
// A frame of up to MAX_BITS bits is loaded one bit per request word (mode
// write); a tick request returns one signed q1.15 i/q sample for the current
// sample position and then advances the counters, and a restart request sets
// the position back to the start of the frame. Each bit is held for
// samples_per_bit samples, the bit index stops at bit_count-1, and the
// position wraps to zero after frame_length samples. The block takes one
// request word every clock with no bubbles: a tick's sample passes through
// the registered read of the bit store and then the result register on its
// way to the rsp port. Backpressure on rsp stalls req only when both
// stages are full. The bit store is split into an even bank and an odd bank
// so that the qpsk bit pair comes out of one read. Bits never written read
// as unknown, so load every bit of the frame before ticking. The user must
// write registers through the csr port only while no request is in flight;
// the block itself does not enforce it. csr_ready is always high.
// ----------------------------------------------------------------------------
module digital_baseband_modulator
   import dbm_pkg::*;
#(
   parameter int MAX_BITS = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   // request words
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   // sample words
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   // register writes
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   // bit index width, bank depth and bank address width
   localparam int BPW  = (MAX_BITS > 2) ? $clog2(MAX_BITS) : 1;
   localparam int ROWS = (MAX_BITS + 1) / 2;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [1:0]           mod_type_ff;
   logic [AMP_WIDTH-1:0] amplitude_ff;
   logic [15:0]          samples_bit_ff;
   logic [8:0]           bit_count_ff;
   logic [15:0]          frame_length_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_type_ff     <= RST_MOD_TYPE;
         amplitude_ff    <= RST_AMPLITUDE;
         samples_bit_ff  <= RST_SAMPLES_BIT;
         bit_count_ff    <= RST_BIT_COUNT;
         frame_length_ff <= RST_FRAME_LENGTH;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MOD_TYPE:     mod_type_ff     <= csr_data[1:0];
            CSR_AMPLITUDE:    amplitude_ff    <= csr_data[AMP_WIDTH-1:0];
            CSR_SAMPLES_BIT:  samples_bit_ff  <= csr_data;
            CSR_BIT_COUNT:    bit_count_ff    <= csr_data[8:0];
            CSR_FRAME_LENGTH: frame_length_ff <= csr_data;
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // request handshake and pipeline control
   // ------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic req_accept;
   logic tick_accept;
   logic write_accept;
   logic restart_accept;

   // result register frees up when empty or being drained
   assign out_free       = !rsp_valid_ff || rsp_ready;
   assign req_ready      = !s1_valid_ff || out_free;
   assign req_accept     = req_valid && req_ready;
   assign tick_accept    = req_accept && (req_data.mode == MODE_TICK);
   assign write_accept   = req_accept && (req_data.mode == MODE_WRITE);
   assign restart_accept = req_accept && (req_data.mode == MODE_RESTART);

   // ------------------------------------------------------------------
   // sample / bit / position counters
   // ------------------------------------------------------------------
   logic [15:0]    sample_pos_ff, sample_pos_in;
   logic [15:0]    sample_bit_ff, sample_bit_in;
   logic [BPW-1:0] bit_pos_ff, bit_pos_in;

   always_comb begin
      sample_pos_in = sample_pos_ff;
      sample_bit_in = sample_bit_ff;
      bit_pos_in    = bit_pos_ff;
      if (restart_accept) begin
         sample_pos_in = '0;
         sample_bit_in = '0;
         bit_pos_in    = '0;
      end else if (tick_accept) begin
         // frame wrap, a zero length behaves as one
         if (({1'b0, sample_pos_ff} + 17'd1) >= {1'b0, frame_length_ff}) begin
            sample_pos_in = '0;
            sample_bit_in = '0;
            bit_pos_in    = '0;
         end else begin
            sample_pos_in = sample_pos_ff + 16'd1;
            if (({1'b0, sample_bit_ff} + 17'd1) >= {1'b0, samples_bit_ff}) begin
               sample_bit_in = '0;
               if ((32'(bit_pos_ff) + 32'd1) < 32'(MAX_BITS)) begin
                  bit_pos_in = bit_pos_ff + BPW'(1);
               end
            end else begin
               sample_bit_in = sample_bit_ff + 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_pos_ff <= '0;
         sample_bit_ff <= '0;
         bit_pos_ff    <= '0;
      end else begin
         sample_pos_ff <= sample_pos_in;
         sample_bit_ff <= sample_bit_in;
         bit_pos_ff    <= bit_pos_in;
      end
   end

   // ------------------------------------------------------------------
   // bit index: counter capped at the last frame bit
   // ------------------------------------------------------------------
   logic [BPW-1:0] last_bit;
   logic [BPW-1:0] bit_idx;
   logic [BPW-1:0] odd_idx;
   logic           odd_in_frame;

   always_comb begin
      // bit_count clamped to 1..MAX_BITS, kept as count minus one
      if (bit_count_ff == 9'd0) begin
         last_bit = '0;
      end else if (32'(bit_count_ff) >= 32'(MAX_BITS)) begin
         last_bit = BPW'(MAX_BITS - 1);
      end else begin
         last_bit = BPW'(bit_count_ff - 9'd1);
      end
   end

   assign bit_idx      = (bit_pos_ff < last_bit) ? bit_pos_ff : last_bit;
   // qpsk partner bit beyond the frame reads as zero
   assign odd_idx      = bit_idx | BPW'(1);
   assign odd_in_frame = (odd_idx <= last_bit);

   // ------------------------------------------------------------------
   // bit store: even and odd banks share a row address
   // ------------------------------------------------------------------
   logic          store_wr_en;
   logic [RW-1:0] store_wr_row;
   logic [RW-1:0] store_rd_row;
   logic          even_bit;
   logic          odd_bit;

   // addresses past the store are dropped
   assign store_wr_en  = write_accept && (32'(req_data.bit_address) < 32'(MAX_BITS));
   assign store_wr_row = RW'(req_data.bit_address >> 1);
   assign store_rd_row = RW'(bit_idx >> 1);

   dbm_ram #(
      .WIDTH (1),
      .DEPTH (ROWS),
      .AW    (RW)
   ) u_even_bank (
      .clock   (clock),
      .wr_en   (store_wr_en && !req_data.bit_address[0]),
      .wr_addr (store_wr_row),
      .wr_data (req_data.bit_value),
      .rd_en   (tick_accept),
      .rd_addr (store_rd_row),
      .rd_data (even_bit)
   );

   dbm_ram #(
      .WIDTH (1),
      .DEPTH (ROWS),
      .AW    (RW)
   ) u_odd_bank (
      .clock   (clock),
      .wr_en   (store_wr_en && req_data.bit_address[0]),
      .wr_addr (store_wr_row),
      .wr_data (req_data.bit_value),
      .rd_en   (tick_accept),
      .rd_addr (store_rd_row),
      .rd_data (odd_bit)
   );

   // ------------------------------------------------------------------
   // stage 1: tick context alongside the store read
   // ------------------------------------------------------------------
   logic [1:0]           s1_mod_ff;
   logic [AMP_WIDTH-1:0] s1_amp_ff;
   logic                 s1_sel_odd_ff;
   logic                 s1_odd_ok_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (tick_accept) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end
   end

   // amplitude is 15 bits, so it never exceeds the 16-bit sample maximum
   always_ff @(posedge clock) begin
      if (tick_accept) begin
         s1_mod_ff     <= mod_type_ff;
         s1_amp_ff     <= amplitude_ff;
         s1_sel_odd_ff <= bit_idx[0];
         s1_odd_ok_ff  <= odd_in_frame;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: symbol mapping into the result register
   // ------------------------------------------------------------------
   logic signed [SAMPLE_WIDTH-1:0] amp_pos;
   logic signed [SAMPLE_WIDTH-1:0] amp_neg;
   logic signed [SAMPLE_WIDTH-1:0] amp_half;
   logic                           sym_bit;
   logic                           q_bit;
   rsp_type                        rsp_data_ff, rsp_data_in;

   assign amp_pos  = {1'b0, s1_amp_ff};
   assign amp_neg  = -amp_pos;
   assign amp_half = amp_pos >>> 1;
   assign sym_bit  = s1_sel_odd_ff ? odd_bit : even_bit;
   assign q_bit    = s1_odd_ok_ff && odd_bit;

   always_comb begin
      rsp_data_in.quadrature = '0;
      case (s1_mod_ff)
         MOD_OOK:  rsp_data_in.in_phase = sym_bit ? amp_pos : '0;
         MOD_ASK:  rsp_data_in.in_phase = sym_bit ? amp_pos : amp_half;
         MOD_BPSK: rsp_data_in.in_phase = sym_bit ? amp_pos : amp_neg;
         MOD_QPSK: begin
            rsp_data_in.in_phase   = even_bit ? amp_pos : amp_neg;
            rsp_data_in.quadrature = q_bit ? amp_neg : amp_pos;
         end
         default: rsp_data_in.in_phase = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && out_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // every accepted tick lands in the read stage
   a_tick_enters: assert property (@(posedge clock) disable iff (reset)
      tick_accept |=> s1_valid_ff)
      else $error("accepted tick did not enter read stage");

   // writes and restarts never create a sample
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_data.mode != MODE_TICK) && !s1_valid_ff) |=> !s1_valid_ff)
      else $error("non-tick request produced a sample");

   // restart clears every counter
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      restart_accept |=> (sample_pos_ff == 16'd0) && (sample_bit_ff == 16'd0)
                         && (bit_pos_ff == '0))
      else $error("restart left counters nonzero");

   // bit counter stays inside the store
   a_bit_pos_range: assert property (@(posedge clock) disable iff (reset)
      32'(bit_pos_ff) < 32'(MAX_BITS))
      else $error("bit position beyond store");

   // a stalled sample is not overwritten by the read stage
   a_stall_keeps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && s1_valid_ff) |=> s1_valid_ff && rsp_valid_ff)
      else $error("pipeline dropped a sample under stall");
`endif

endmodule
